@@ src/lzwr_pkg.sv @@
// Shared constants, codes and handshake types of the LZW/RLE90 pixel decoder.
package lzwr_pkg;

	localparam int MAX_CODE_WIDTH = 11;
	localparam int DICT_AW        = MAX_CODE_WIDTH;
	localparam int DICT_SIZE      = 1 << MAX_CODE_WIDTH;
	localparam int STACK_DEPTH    = 2048;
	localparam int STACK_AW       = $clog2(STACK_DEPTH);
	localparam int LEVEL_W        = STACK_AW + 1;
	localparam int NEXT_W         = MAX_CODE_WIDTH + 1;
	localparam int BUF_BITS       = 18;
	localparam int FILL_W         = 5;
	localparam int CW_W           = 4;
	localparam int TOTAL_W        = 21;

	localparam logic [7:0] ESCAPE_BYTE   = 8'h90;
	localparam logic [3:0] FIRST_WIDTH   = 4'd9;
	localparam int         FIRST_FREE    = 256;
	localparam logic [4:0] FEED_LIMIT    = 5'd10;

	localparam logic [1:0] OP_FEED    = 2'd0;
	localparam logic [1:0] OP_FETCH   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [2:0] ST_PAIR     = 3'd0;
	localparam logic [2:0] ST_STARVED  = 3'd1;
	localparam logic [2:0] ST_TAKEN    = 3'd2;
	localparam logic [2:0] ST_REFUSED  = 3'd3;
	localparam logic [2:0] ST_FINISHED = 3'd4;
	localparam logic [2:0] ST_RESTART  = 3'd5;

	typedef struct packed {
		logic       feed;
		logic       fetch;
		logic       clear;
		logic [7:0] data;
	} lzwr_cmd_t;

	typedef struct packed {
		logic       done;
		logic       starved;
		logic [7:0] data;
	} lzwr_rsp_t;

endpackage

@@ src/lzw_rle90_nibble_decoder_top.sv @@
// Top level: transaction handling, run escape, pixel count and output register.
//
// Input channel (in_valid/in_stall) carries operation and feed_byte; output
// channel (out_valid/out_stall) returns status, pixel_first, pixel_second and
// last_pair, one result per input transaction, in order.
// Feed, restart, finished and unknown operations are answered straight from
// the idle state, as is a fetch that repeats a run byte. A fetch served from
// the character stack passes the pop states of the LZW unit; one that decodes
// a new code first walks its dictionary chain, where the shared dictionary
// read port returns one link per cycle, then adds the entry and pops. A run
// escape fetches two bytes, so its cost is the sum of both.
// The block holds one transaction at a time: in_stall is high while a
// fetch is in work and while a result waits on a stalled output.
// cfg_wen/cfg_wdata write pixel_total; write it only while idle.
// Reset (arst_n low) clears all decode state and sets pixel_total to 64000;
// no clearing pass is needed, dictionary and stack are only read where
// written. A restart operation does the same but keeps pixel_total.
// While out_stall is high the result and its valid hold unchanged.
module lzw_rle90_nibble_decoder_top import lzwr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [TOTAL_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [7:0]         feed_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [3:0]         pixel_first,
	output logic [3:0]         pixel_second,
	output logic               last_pair
);

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_WAIT1 = 2'd1;
	localparam logic [1:0] T_WAIT2 = 2'd2;

	logic [1:0]         state_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] done_q;
	logic [7:0]         run_left_q;
	logic [7:0]         cur_q;
	logic               esc_q;
	logic               req_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [7:0]         byte_q;
	logic               last_q;

	lzwr_cmd_t          cmd;
	lzwr_rsp_t          rsp;
	logic               feed_full;
	logic               accept;
	logic [TOTAL_W:0]   done_inc;
	logic               is_last;

	assign in_stall     = (state_q != T_IDLE) || (out_valid_q && out_stall);
	assign accept       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign pixel_first  = byte_q[3:0];
	assign pixel_second = byte_q[7:4];
	assign last_pair    = last_q;

	assign done_inc = {1'b0, done_q} + (TOTAL_W+1)'(2);
	assign is_last  = done_inc >= {1'b0, total_q};

	// Issue commands to the LZW unit
	assign cmd.feed  = accept && operation == OP_FEED;
	assign cmd.clear = accept && operation == OP_RESTART;
	assign cmd.fetch = req_q;
	assign cmd.data  = feed_byte;

	lzwr_lzw u_lzw (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.feed_full (feed_full),
		.rsp       (rsp)
	);

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_W'(64000);
		end else if (cfg_wen) begin
			total_q <= cfg_wdata;
		end
	end

	// Sequence transactions and answer them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			done_q      <= '0;
			run_left_q  <= '0;
			cur_q       <= '0;
			esc_q       <= 1'b0;
			req_q       <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_PAIR;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			req_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						out_valid_q <= 1'b1;
						byte_q      <= '0;
						last_q      <= 1'b0;
						case (operation)
							OP_FEED: begin
								status_q <= feed_full ? ST_REFUSED : ST_TAKEN;
							end
							OP_RESTART: begin
								done_q     <= '0;
								run_left_q <= '0;
								cur_q      <= '0;
								esc_q      <= 1'b0;
								status_q   <= ST_RESTART;
							end
							OP_FETCH: begin
								if (done_q >= total_q) begin
									status_q <= ST_FINISHED;
								end else if (run_left_q != '0) begin
									run_left_q <= run_left_q - 8'd1;
									status_q   <= ST_PAIR;
									byte_q     <= cur_q;
									last_q     <= is_last;
									done_q     <= is_last ? total_q : done_inc[TOTAL_W-1:0];
								end else begin
									out_valid_q <= 1'b0;
									req_q       <= 1'b1;
									state_q     <= esc_q ? T_WAIT2 : T_WAIT1;
								end
							end
							default: begin
								status_q <= ST_REFUSED;
							end
						endcase
					end
				end
				T_WAIT1: begin
					if (rsp.done) begin
						if (rsp.starved) begin
							out_valid_q <= 1'b1;
							status_q    <= ST_STARVED;
							byte_q      <= '0;
							last_q      <= 1'b0;
							state_q     <= T_IDLE;
						end else if (rsp.data != ESCAPE_BYTE) begin
							cur_q       <= rsp.data;
							out_valid_q <= 1'b1;
							status_q    <= ST_PAIR;
							byte_q      <= rsp.data;
							last_q      <= is_last;
							done_q      <= is_last ? total_q : done_inc[TOTAL_W-1:0];
							state_q     <= T_IDLE;
						end else begin
							esc_q   <= 1'b1;
							req_q   <= 1'b1;
							state_q <= T_WAIT2;
						end
					end
				end
				T_WAIT2: begin
					if (rsp.done) begin
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
						if (rsp.starved) begin
							status_q <= ST_STARVED;
							byte_q   <= '0;
							last_q   <= 1'b0;
						end else begin
							esc_q    <= 1'b0;
							status_q <= ST_PAIR;
							last_q   <= is_last;
							done_q   <= is_last ? total_q : done_inc[TOTAL_W-1:0];
							if (rsp.data == '0) begin
								cur_q  <= ESCAPE_BYTE;
								byte_q <= ESCAPE_BYTE;
							end else begin
								run_left_q <= (rsp.data >= 8'd2) ? rsp.data - 8'd2 : 8'd0;
								byte_q     <= cur_q;
							end
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/lzwr_lzw.sv @@
// LZW code unpacker, dictionary chain walker and character stack.
module lzwr_lzw import lzwr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lzwr_cmd_t cmd,
	output logic      feed_full,
	output lzwr_rsp_t rsp
);

	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_WALK = 3'd1;
	localparam logic [2:0] U_FIN  = 3'd2;
	localparam logic [2:0] U_POP  = 3'd3;
	localparam logic [2:0] U_POPW = 3'd4;

	logic [2:0]          state_q;
	logic [BUF_BITS-1:0] buf_q;
	logic [FILL_W-1:0]   fill_q;
	logic [CW_W-1:0]     width_q;
	logic [NEXT_W-1:0]   next_free_q;
	logic [DICT_AW-1:0]  prev_code_q;
	logic [7:0]          prev_first_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [DICT_AW-1:0]  idx_q;
	logic [DICT_AW-1:0]  newprev_q;
	logic [NEXT_W-1:0]   guard_q;
	lzwr_rsp_t           rsp_q;

	logic [7:0]         dict_char_mem [DICT_SIZE];
	logic [DICT_AW-1:0] dict_link_mem [DICT_SIZE];
	logic [7:0]         stack_mem [STACK_DEPTH];
	logic [7:0]         char_rd_q;
	logic [DICT_AW-1:0] link_rd_q;
	logic [7:0]         stack_rd_q;

	logic [NEXT_W-1:0]  mask;
	logic [DICT_AW-1:0] code;
	logic               kwk;
	logic [DICT_AW-1:0] start_idx;
	logic [DICT_AW-1:0] dict_raddr;
	logic [NEXT_W-1:0]  next_inc;
	logic               can_push;
	logic               push_en;
	logic [7:0]         push_data;
	logic [STACK_AW-1:0] stack_raddr;

	// Decode the code at the bottom of the bit buffer
	assign mask      = (NEXT_W'(1) << width_q) - NEXT_W'(1);
	assign code      = buf_q[DICT_AW-1:0] & mask[DICT_AW-1:0];
	assign kwk       = {1'b0, code} >= next_free_q;
	assign start_idx = kwk ? prev_code_q : code;
	assign next_inc  = next_free_q + NEXT_W'(1);
	assign can_push  = level_q < LEVEL_W'(STACK_DEPTH);
	assign feed_full = fill_q > FEED_LIMIT;
	assign rsp       = rsp_q;

	// Select dictionary read address: chain start or the link just read
	assign dict_raddr  = (state_q == U_WALK) ? link_rd_q : start_idx;
	assign stack_raddr = STACK_AW'(level_q - LEVEL_W'(1));

	// Pick the stack push of this cycle
	always_comb begin
		push_en   = 1'b0;
		push_data = prev_first_q;
		case (state_q)
			U_IDLE: begin
				push_en   = cmd.fetch && level_q == '0 && fill_q >= FILL_W'(width_q) && kwk;
				push_data = prev_first_q;
			end
			U_WALK: begin
				push_en   = 1'b1;
				push_data = char_rd_q;
			end
			U_FIN: begin
				push_en   = 1'b1;
				push_data = idx_q[7:0];
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// Dictionary and stack memories
	always_ff @(posedge clk) begin
		char_rd_q  <= dict_char_mem[dict_raddr];
		link_rd_q  <= dict_link_mem[dict_raddr];
		stack_rd_q <= stack_mem[stack_raddr];
		if (state_q == U_FIN && next_free_q < NEXT_W'(DICT_SIZE)) begin
			dict_char_mem[next_free_q[DICT_AW-1:0]] <= idx_q[7:0];
			dict_link_mem[next_free_q[DICT_AW-1:0]] <= prev_code_q;
		end
		if (push_en && can_push) begin
			stack_mem[level_q[STACK_AW-1:0]] <= push_data;
		end
	end

	// Sequence feed, clear, decode, chain walk, entry add and pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= U_IDLE;
			buf_q        <= '0;
			fill_q       <= '0;
			width_q      <= FIRST_WIDTH;
			next_free_q  <= NEXT_W'(FIRST_FREE);
			prev_code_q  <= '0;
			prev_first_q <= '0;
			level_q      <= '0;
			idx_q        <= '0;
			newprev_q    <= '0;
			guard_q      <= '0;
			rsp_q        <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			if (push_en && can_push) begin
				level_q <= level_q + LEVEL_W'(1);
			end
			case (state_q)
				U_IDLE: begin
					if (cmd.clear) begin
						buf_q        <= '0;
						fill_q       <= '0;
						width_q      <= FIRST_WIDTH;
						next_free_q  <= NEXT_W'(FIRST_FREE);
						prev_code_q  <= '0;
						prev_first_q <= '0;
						level_q      <= '0;
					end else if (cmd.feed) begin
						if (!feed_full) begin
							buf_q  <= buf_q | (BUF_BITS'(cmd.data) << fill_q);
							fill_q <= fill_q + FILL_W'(8);
						end
					end else if (cmd.fetch) begin
						if (level_q != '0) begin
							state_q <= U_POP;
						end else if (fill_q < FILL_W'(width_q)) begin
							rsp_q.done    <= 1'b1;
							rsp_q.starved <= 1'b1;
							rsp_q.data    <= '0;
						end else begin
							buf_q     <= buf_q >> width_q;
							fill_q    <= fill_q - FILL_W'(width_q);
							newprev_q <= kwk ? next_free_q[DICT_AW-1:0] : code;
							idx_q     <= start_idx;
							guard_q   <= '0;
							state_q   <= (start_idx >= DICT_AW'(FIRST_FREE)) ? U_WALK : U_FIN;
						end
					end
				end
				U_WALK: begin
					guard_q <= guard_q + NEXT_W'(1);
					idx_q   <= link_rd_q;
					if (!(link_rd_q >= DICT_AW'(FIRST_FREE)
							&& guard_q + NEXT_W'(1) < NEXT_W'(DICT_SIZE))) begin
						state_q <= U_FIN;
					end
				end
				U_FIN: begin
					if (width_q == CW_W'(MAX_CODE_WIDTH) && next_inc > mask) begin
						width_q      <= FIRST_WIDTH;
						next_free_q  <= NEXT_W'(FIRST_FREE);
						prev_code_q  <= '0;
						prev_first_q <= '0;
					end else begin
						if (next_inc > mask) begin
							width_q <= width_q + CW_W'(1);
						end
						next_free_q  <= next_inc;
						prev_code_q  <= newprev_q;
						prev_first_q <= idx_q[7:0];
					end
					state_q <= U_POP;
				end
				U_POP: begin
					if (level_q == '0) begin
						rsp_q.done    <= 1'b1;
						rsp_q.starved <= 1'b0;
						rsp_q.data    <= '0;
						state_q       <= U_IDLE;
					end else begin
						level_q <= level_q - LEVEL_W'(1);
						state_q <= U_POPW;
					end
				end
				U_POPW: begin
					rsp_q.done    <= 1'b1;
					rsp_q.starved <= 1'b0;
					rsp_q.data    <= stack_rd_q;
					state_q       <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

endmodule
